// ===== rtl/ins_frame_parser_xor_check_assert.svh =====
// Assertion macros for the frame parser.
`ifndef INS_FRAME_PARSER_XOR_CHECK_ASSERT_SVH
`define INS_FRAME_PARSER_XOR_CHECK_ASSERT_SVH
`ifndef SYNTH
`define IFPX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IFPX_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IFPX_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define IFPX_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ifpx_pkg.sv =====
// Shared constants, types and helpers of the frame parser.
package ifpx_pkg;

   localparam int FRAME_BYTES   = 58;
   localparam int PAYLOAD_FIRST = 3;
   localparam int PLD_BYTES     = 36;
   localparam int NUM_FIELDS    = 15;
   localparam int QDEPTH        = 2;

   localparam int POS_W     = $clog2(FRAME_BYTES);
   localparam int PLD_OFF_W = $clog2(PLD_BYTES + 1);
   localparam int MEM_DEPTH = 2 * PLD_BYTES;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic [7:0] HDR0 = 8'hBD;
   localparam logic [7:0] HDR1 = 8'hDB;
   localparam logic [7:0] HDR2 = 8'h0B;

   localparam logic [3:0] FIRST_WIDE_FIELD = 4'd9;
   localparam logic [3:0] LAST_WIDE_FIELD  = 4'd11;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // one judged frame waiting for the back end
   typedef struct packed {
      logic ok;
      logic bank;
   } job_type;

   // payload store write port
   typedef struct packed {
      logic                 en;
      logic                 bank;
      logic [PLD_OFF_W-1:0] offset;
      logic [7:0]           data;
   } wr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_CAPTURE,
      BK_SEND
   } back_state_type;

   // lat, lon and alt are 32-bit fields
   function automatic logic is_wide_field(input logic [3:0] idx);
      return (idx >= FIRST_WIDE_FIELD) && (idx <= LAST_WIDE_FIELD);
   endfunction

endpackage

// ===== rtl/ifpx_req_if.sv =====
// Input byte channel.
interface ifpx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ifpx_rsp_if.sv =====
// Result channel.
interface ifpx_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         field_index;
   logic signed [31:0] field_value;
   logic               frame_status;
   logic               last_of_frame;

   modport source (output valid, output field_index, output field_value,
                   output frame_status, output last_of_frame, input ready);
   modport sink   (input valid, input field_index, input field_value,
                   input frame_status, input last_of_frame, output ready);
endinterface

// ===== rtl/ins_frame_parser_xor_check.sv =====
// A good frame's fields are read from the payload store byte by byte; an error word is sent straight from idle.
// Throughput: one byte per cycle in while the job queue is not full; fields are read through the
// single read port of the payload store (one byte per read, registered data).
// Two judged frames may wait in the job queue; the input stalls while both are pending.
// Reset (synchronous): hunt restarts, XOR cleared, check enabled, queue emptied; payload not cleared.
`include "ins_frame_parser_xor_check_assert.svh"
module ins_frame_parser_xor_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   ifpx_req_if.sink    req_ch,
   ifpx_rsp_if.source  rsp_ch
);
   import ifpx_pkg::*;

   logic    q_push, q_pop, q_empty, q_full;
   job_type push_job, head_job;
   wr_type  pld_wr;

   ifpx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .pld_wr      (pld_wr)
   );

   ifpx_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   ifpx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pld_wr   (pld_wr),
      .q_empty  (q_empty),
      .head_job (head_job),
      .q_pop    (q_pop),
      .rsp      (rsp_ch)
   );

   `IFPX_ASSERT_IMP(a_no_push_full, clock, reset, q_push, !q_full, "job pushed into full queue")
   `IFPX_ASSERT_IMP(a_no_pop_empty, clock, reset, q_pop, !q_empty, "job popped from empty queue")
   `IFPX_ASSERT_IMP(a_last_pops, clock, reset, rsp_ch.valid && rsp_ch.ready && rsp_ch.last_of_frame, q_pop, "last word of frame did not retire its job")
   `IFPX_ASSERT_IMP(a_err_word, clock, reset, rsp_ch.valid && rsp_ch.frame_status, rsp_ch.last_of_frame && (rsp_ch.field_value == 32'sd0) && (rsp_ch.field_index == 4'd0), "malformed error word")
   `IFPX_ASSERT_NXT(a_full_stalls, clock, reset, q_full && !q_pop, !req_ch.ready, "input not stalled with queue full")

endmodule

// ===== rtl/ifpx_front.sv =====
// Front end: header hunt, byte position count, XOR check and payload writes.
module ifpx_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   ifpx_req_if.sink        req,
   input  logic            q_full,
   output logic            q_push,
   output ifpx_pkg::job_type q_job,
   output ifpx_pkg::wr_type  pld_wr
);
   import ifpx_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic             bank_ff, bank_in;
   logic             chk_en_ff;
   logic             accept;
   logic [7:0]       b;

   // stalling every word while two frames wait keeps the write bank free
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;

   always_comb begin
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      bank_in       = bank_ff;
      q_push        = 1'b0;
      q_job.ok      = 1'b0;
      q_job.bank    = bank_ff;
      pld_wr.en     = 1'b0;
      pld_wr.bank   = bank_ff;
      pld_wr.offset = PLD_OFF_W'(pos_ff - POS_W'(PAYLOAD_FIRST));
      pld_wr.data   = b;
      if (accept) begin
         if (pos_ff == '0) begin
            if (b == HDR0) begin
               xor_in = HDR0;
               pos_in = POS_W'(1);
            end
         end else if (pos_ff == POS_W'(1) || pos_ff == POS_W'(2)) begin
            if (b == ((pos_ff == POS_W'(1)) ? HDR1 : HDR2)) begin
               xor_in = xor_ff ^ b;
               pos_in = pos_ff + POS_W'(1);
            end else if (b == HDR0) begin
               xor_in = HDR0;
               pos_in = POS_W'(1);
            end else begin
               xor_in = '0;
               pos_in = '0;
            end
         end else if (pos_ff < POS_W'(FRAME_BYTES - 1)) begin
            xor_in = xor_ff ^ b;
            pos_in = pos_ff + POS_W'(1);
            pld_wr.en = (pos_ff < POS_W'(PAYLOAD_FIRST + PLD_BYTES));
         end else begin
            // check byte
            q_push   = 1'b1;
            q_job.ok = !chk_en_ff || (xor_ff == b);
            bank_in  = !bank_ff;
            xor_in   = '0;
            pos_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         xor_ff    <= '0;
         bank_ff   <= 1'b0;
         chk_en_ff <= 1'b1;
      end else begin
         pos_ff  <= pos_in;
         xor_ff  <= xor_in;
         bank_ff <= bank_in;
         if (csr_wr_en) begin
            chk_en_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== rtl/ifpx_job_queue.sv =====
// Short FIFO of judged frames between front and back end.
module ifpx_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ifpx_pkg::job_type push_job,
   input  logic              pop,
   output ifpx_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);
   import ifpx_pkg::*;

   job_type             entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_job = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== rtl/ifpx_back.sv =====
// Back end: double-banked payload store and field emitter.
module ifpx_back (
   input  logic              clock,
   input  logic              reset,
   input  ifpx_pkg::wr_type  pld_wr,
   input  logic              q_empty,
   input  ifpx_pkg::job_type head_job,
   output logic              q_pop,
   ifpx_rsp_if.source        rsp
);
   import ifpx_pkg::*;

   logic [7:0]           mem [MEM_DEPTH];
   logic [7:0]           rd_data_ff;
   logic [MEM_AW-1:0]    wr_addr, rd_addr;

   back_state_type       state_ff, state_in;
   logic [PLD_OFF_W-1:0] off_ff, off_in;
   logic [3:0]           fidx_ff, fidx_in;
   logic [1:0]           bsel_ff, bsel_in;
   logic [31:0]          acc_ff, acc_in;
   logic [3:0]           idx_ff, idx_in;
   logic [31:0]          val_ff, val_in;
   logic                 stat_ff, stat_in;
   logic                 last_ff, last_in;
   logic                 wide;
   logic                 field_done;

   // bank 1 sits above bank 0
   assign wr_addr = pld_wr.bank ? MEM_AW'(pld_wr.offset) + MEM_AW'(PLD_BYTES)
                                : MEM_AW'(pld_wr.offset);
   assign rd_addr = head_job.bank ? MEM_AW'(off_ff) + MEM_AW'(PLD_BYTES)
                                  : MEM_AW'(off_ff);

   always_ff @(posedge clock) begin
      if (pld_wr.en) begin
         mem[wr_addr] <= pld_wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign wide       = is_wide_field(fidx_ff);
   assign field_done = (bsel_ff == (wide ? 2'd3 : 2'd1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = head_job.ok ? BK_READ : BK_SEND;
            end
         end
         BK_READ:    state_in = BK_CAPTURE;
         BK_CAPTURE: state_in = field_done ? BK_SEND : BK_READ;
         BK_SEND: begin
            if (rsp.ready) begin
               state_in = last_ff ? BK_IDLE : BK_READ;
            end
         end
         default:    state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      off_in  = off_ff;
      fidx_in = fidx_ff;
      bsel_in = bsel_ff;
      acc_in  = acc_ff;
      idx_in  = idx_ff;
      val_in  = val_ff;
      stat_in = stat_ff;
      last_in = last_ff;
      q_pop   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            off_in  = '0;
            fidx_in = '0;
            bsel_in = '0;
            // error result loads straight away
            idx_in  = '0;
            val_in  = '0;
            stat_in = STATUS_BAD;
            last_in = 1'b1;
         end
         BK_READ: begin
            off_in = off_ff + PLD_OFF_W'(1);
         end
         BK_CAPTURE: begin
            acc_in[{bsel_ff, 3'b000} +: 8] = rd_data_ff;
            if (field_done) begin
               bsel_in = '0;
               idx_in  = fidx_ff;
               val_in  = wide ? acc_in : {{16{acc_in[15]}}, acc_in[15:0]};
               stat_in = STATUS_OK;
               last_in = (fidx_ff == 4'(NUM_FIELDS - 1));
            end else begin
               bsel_in = bsel_ff + 2'd1;
            end
         end
         BK_SEND: begin
            if (rsp.ready) begin
               fidx_in = fidx_ff + 4'd1;
               q_pop   = last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid         = (state_ff == BK_SEND);
   assign rsp.field_index   = idx_ff;
   assign rsp.field_value   = val_ff;
   assign rsp.frame_status  = stat_ff;
   assign rsp.last_of_frame = last_ff;

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      fidx_ff <= fidx_in;
      bsel_ff <= bsel_in;
      acc_ff  <= acc_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      stat_ff <= stat_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
